### hw/rtl/tlpc_pkg.sv
// Shared widths, types and setup step codes for the triangle lattice point counter.
`timescale 1ns / 1ps
`default_nettype none

package tlpc_pkg;

  localparam int COORD_W = 16;
  localparam int GRID_W  = 8;
  localparam int COUNT_W = 16;
  localparam int OPND_W  = 20;
  localparam int ACC_W   = 2 * OPND_W;
  localparam int STEP_W  = 4;

  typedef logic signed [OPND_W-1:0] opnd_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic [STEP_W-1:0]        step_t;

  localparam step_t STEP_AREA_A = 4'd0;
  localparam step_t STEP_AREA_B = 4'd1;
  localparam step_t STEP_EDGE0  = 4'd2;
  localparam step_t STEP_LAST   = 4'd14;

  localparam logic [1:0] SUB_ORIGIN_Y = 2'd0;
  localparam logic [1:0] SUB_ORIGIN_X = 2'd1;
  localparam logic [1:0] SUB_STEP_J   = 2'd2;
  localparam logic [1:0] SUB_STEP_I   = 2'd3;

endpackage

`default_nettype wire

### hw/rtl/triangle_lattice_point_count.sv
// Top level of the triangle lattice point counter with shared multiplier and grid scan.
// Each triangle first runs its setup steps on the shared multiplier, then scans grid_last * grid_last
// grid points and loads the result register; a degenerate triangle or a zero grid_last skips
// the scan. The grid scan covers one point per cycle, and the next triangle is accepted only
// in the idle state, after the previous result has been loaded. Reset is
// synchronous and active high; it restores grid_last to 99, returns the sequencer to idle
// and drops the result valid.
`timescale 1ns / 1ps
`default_nettype none

module triangle_lattice_point_count import tlpc_pkg::*; #(
  parameter int COORD_SCALE = 100
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [2:0]          paddr,
  input  wire  [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  wire                 item_valid,
  output logic                item_ready,
  input  wire  [COORD_W-1:0]  vertex_a_x,
  input  wire  [COORD_W-1:0]  vertex_a_y,
  input  wire  [COORD_W-1:0]  vertex_b_x,
  input  wire  [COORD_W-1:0]  vertex_b_y,
  input  wire  [COORD_W-1:0]  vertex_c_x,
  input  wire  [COORD_W-1:0]  vertex_c_y,
  output logic                result_valid,
  input  wire                 result_ready,
  output logic [COUNT_W-1:0]  point_count,
  output logic                degenerate
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SETUP  = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  localparam opnd_t SCALE_OP = OPND_W'(COORD_SCALE);

  logic [1:0]         state;
  step_t              step;
  logic [GRID_W-1:0]  grid_last;
  logic [COORD_W-1:0] vx [3];
  logic [COORD_W-1:0] vy [3];
  opnd_t              dx [3];
  opnd_t              dy [3];
  acc_t               edge_val [3];
  acc_t               row_val  [3];
  acc_t               step_j   [3];
  acc_t               step_i   [3];
  acc_t               area;
  acc_t               prod;
  logic [GRID_W-1:0]  i_cnt;
  logic [GRID_W-1:0]  j_cnt;
  logic [COUNT_W-1:0] count;
  logic               fin_degen;

  opnd_t              opa;
  opnd_t              opb;
  step_t              op_rel;
  step_t              wb_step;
  step_t              wb_rel;
  logic [1:0]         wb_edge;
  logic [1:0]         op_edge;
  logic               covered;
  logic               area_neg;
  logic [2:0]         edge_ok;
  acc_t               row_next [3];

  assign pready     = 1'b1;
  assign prdata     = {24'd0, grid_last};
  assign item_ready = (state == ST_IDLE);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dx[k] = OPND_W'(vx[(k + 1) % 3]) - OPND_W'(vx[k]);
      dy[k] = OPND_W'(vy[(k + 1) % 3]) - OPND_W'(vy[k]);
    end
  end

  assign op_rel  = step - STEP_EDGE0;
  assign op_edge = op_rel[3:2];

  always_comb begin
    opa = '0;
    opb = '0;
    if (step == STEP_AREA_A) begin
      opa = dx[0];
      opb = OPND_W'(vy[2]) - OPND_W'(vy[0]);
    end else if (step == STEP_AREA_B) begin
      opa = dy[0];
      opb = OPND_W'(vx[2]) - OPND_W'(vx[0]);
    end else if (op_edge != 2'd3) begin
      case (op_rel[1:0])
        SUB_ORIGIN_Y: begin
          opa = dx[op_edge];
          opb = SCALE_OP - OPND_W'(vy[op_edge]);
        end
        SUB_ORIGIN_X: begin
          opa = dy[op_edge];
          opb = SCALE_OP - OPND_W'(vx[op_edge]);
        end
        SUB_STEP_J: begin
          opa = dx[op_edge];
          opb = SCALE_OP;
        end
        default: begin
          opa = dy[op_edge];
          opb = SCALE_OP;
        end
      endcase
    end
  end

  assign wb_step = step - 4'd1;
  assign wb_rel  = wb_step - STEP_EDGE0;
  assign wb_edge = wb_rel[3:2];

  assign area_neg = area[ACC_W-1];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      edge_ok[k]  = area_neg ? (edge_val[k][ACC_W-1] || (edge_val[k] == '0))
                             : !edge_val[k][ACC_W-1];
      row_next[k] = row_val[k] - step_i[k];
    end
    covered = &edge_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_last <= 8'd99;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      grid_last <= pwdata[GRID_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && (state != ST_FINISH)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            vx[0] <= vertex_a_x;
            vy[0] <= vertex_a_y;
            vx[1] <= vertex_b_x;
            vy[1] <= vertex_b_y;
            vx[2] <= vertex_c_x;
            vy[2] <= vertex_c_y;
            step  <= '0;
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          prod <= $signed(opa) * $signed(opb);
          step <= step + 4'd1;
          if (step != STEP_AREA_A) begin
            if (wb_step == STEP_AREA_A) begin
              area <= prod;
            end else if (wb_step == STEP_AREA_B) begin
              area <= area - prod;
            end else begin
              case (wb_rel[1:0])
                SUB_ORIGIN_Y: edge_val[wb_edge] <= prod;
                SUB_ORIGIN_X: begin
                  edge_val[wb_edge] <= edge_val[wb_edge] - prod;
                  row_val[wb_edge]  <= edge_val[wb_edge] - prod;
                end
                SUB_STEP_J: step_j[wb_edge] <= prod;
                default:    step_i[wb_edge] <= prod;
              endcase
            end
          end
          if (step == STEP_LAST) begin
            count     <= '0;
            i_cnt     <= 8'd1;
            j_cnt     <= 8'd1;
            fin_degen <= (area == '0);
            if ((area == '0) || (grid_last == '0)) begin
              state <= ST_FINISH;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          count <= count + COUNT_W'(covered);
          if (j_cnt == grid_last) begin
            j_cnt <= 8'd1;
            i_cnt <= i_cnt + 8'd1;
            for (int k = 0; k < 3; k++) begin
              row_val[k]  <= row_next[k];
              edge_val[k] <= row_next[k];
            end
            if (i_cnt == grid_last) begin
              state <= ST_FINISH;
            end
          end else begin
            j_cnt <= j_cnt + 8'd1;
            for (int k = 0; k < 3; k++) begin
              edge_val[k] <= edge_val[k] + step_j[k];
            end
          end
        end
        default: begin
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            point_count  <= count;
            degenerate   <= fin_degen;
            state        <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### tb/triangle_lattice_point_count_tb.sv
// Self-checking testbench for the triangle lattice point counter.
`timescale 1ns / 1ps

module triangle_lattice_point_count_tb;
  import tlpc_pkg::*;

  localparam logic [2:0] ADDR_GRID_LAST = 3'd0;
  localparam logic [2:0] ADDR_UNUSED    = 3'd4;
  localparam int IDLE_PCT      = 34;
  localparam int QUIET_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 50;
  localparam int RANDOM_ITEMS  = 70;
  localparam int N_DIRECTED    = 16;
  localparam bit TYPED         = 1'b1;
  localparam bit PREDICT       = 1'b0;

  typedef struct packed {
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] by;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
  } triangle_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               degen;
  } tally_t;

  typedef struct packed {
    triangle_t shape;
    bit        typed;
    tally_t    want;
  } shape_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               item_valid = 1'b0;
  logic               item_ready;
  triangle_t          shape_in = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  logic [COUNT_W-1:0] point_count;
  logic               degenerate;

  logic [GRID_W-1:0]  grid_model = 8'd99;
  logic               calm = 1'b0;
  tally_t             expected_tallies [$];
  int                 mismatches = 0;
  int                 quiet_cycles = 0;

  shape_row_t directed_rows [N_DIRECTED] = '{
    '{'{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, TYPED, '{16'd0, 1'b1}},
    '{'{16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535},
      TYPED, '{16'd0, 1'b1}},
    '{'{16'd100, 16'd100, 16'd100, 16'd100, 16'd500, 16'd300}, TYPED, '{16'd0, 1'b1}},
    '{'{16'd0, 16'd0, 16'd100, 16'd100, 16'd9900, 16'd9900}, TYPED, '{16'd0, 1'b1}},
    '{'{16'd0, 16'd0, 16'd50, 16'd0, 16'd0, 16'd50}, TYPED, '{16'd0, 1'b0}},
    '{'{16'd0, 16'd0, 16'd65535, 16'd0, 16'd0, 16'd65535}, TYPED, '{16'd9801, 1'b0}},
    '{'{16'd0, 16'd0, 16'd0, 16'd65535, 16'd65535, 16'd0}, TYPED, '{16'd9801, 1'b0}},
    '{'{16'd100, 16'd100, 16'd9900, 16'd100, 16'd100, 16'd9900}, PREDICT, '0},
    '{'{16'd100, 16'd100, 16'd100, 16'd9900, 16'd9900, 16'd100}, PREDICT, '0},
    '{'{16'd100, 16'd100, 16'd101, 16'd100, 16'd100, 16'd101}, PREDICT, '0},
    '{'{16'd200, 16'd300, 16'd700, 16'd800, 16'd1200, 16'd100}, PREDICT, '0},
    '{'{16'd65535, 16'd65535, 16'd0, 16'd65535, 16'd65535, 16'd0}, PREDICT, '0},
    '{'{16'd10000, 16'd10000, 16'd20000, 16'd10000, 16'd10000, 16'd20000}, PREDICT, '0},
    '{'{16'd1234, 16'd5678, 16'd8765, 16'd4321, 16'd3000, 16'd9000}, PREDICT, '0},
    '{'{16'd0, 16'd500, 16'd65535, 16'd500, 16'd0, 16'd501}, PREDICT, '0},
    '{'{16'd9900, 16'd9900, 16'd9950, 16'd9900, 16'd9900, 16'd9950}, PREDICT, '0}
  };

  triangle_lattice_point_count dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .vertex_a_x   (shape_in.ax),
    .vertex_a_y   (shape_in.ay),
    .vertex_b_x   (shape_in.bx),
    .vertex_b_y   (shape_in.by),
    .vertex_c_x   (shape_in.cx),
    .vertex_c_y   (shape_in.cy),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .point_count  (point_count),
    .degenerate   (degenerate)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint edge_cross(longint ux, longint uy, longint vx, longint vy,
                                        longint px, longint py);
    return (vx - ux) * (py - uy) - (vy - uy) * (px - ux);
  endfunction

  function automatic tally_t count_lattice_points(triangle_t t, logic [GRID_W-1:0] last);
    longint ax, ay, bx, by, cx, cy;
    longint area2, orient, px, py;
    int unsigned hits;
    tally_t r;
    ax = t.ax;
    ay = t.ay;
    bx = t.bx;
    by = t.by;
    cx = t.cx;
    cy = t.cy;
    hits = 0;
    area2 = edge_cross(ax, ay, bx, by, cx, cy);
    if (area2 == 0) begin
      r.count = '0;
      r.degen = 1'b1;
      return r;
    end
    orient = (area2 < 0) ? -1 : 1;
    for (int i = 1; i <= int'(last); i++) begin
      px = i * 100;
      for (int j = 1; j <= int'(last); j++) begin
        py = j * 100;
        if (orient * edge_cross(ax, ay, bx, by, px, py) >= 0 &&
            orient * edge_cross(bx, by, cx, cy, px, py) >= 0 &&
            orient * edge_cross(cx, cy, ax, ay, px, py) >= 0)
          hits++;
      end
    end
    r.count = hits[COUNT_W-1:0];
    r.degen = 1'b0;
    return r;
  endfunction

  // Most triangles are drawn near the active grid so that they actually cover points.
  function automatic triangle_t random_triangle(logic [GRID_W-1:0] last);
    int span;
    int x, y, dx, dy;
    triangle_t t;
    span = (int'(last) + 1) * 100 + 50;
    case ($urandom_range(9))
      0: begin
        t = {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
             16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
             16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))};
      end
      1: begin
        x = $urandom_range(0, span);
        y = $urandom_range(0, span);
        dx = $urandom_range(0, span / 2);
        dy = $urandom_range(0, span / 2);
        t = {16'(x), 16'(y), 16'(x + 2 * dx), 16'(y + 2 * dy), 16'(x + dx), 16'(y + dy)};
      end
      2: begin
        t = {16'($urandom_range(0, last + 1) * 100), 16'($urandom_range(0, last + 1) * 100),
             16'($urandom_range(0, last + 1) * 100), 16'($urandom_range(0, last + 1) * 100),
             16'($urandom_range(0, last + 1) * 100), 16'($urandom_range(0, last + 1) * 100)};
      end
      default: begin
        t = {16'($urandom_range(0, span)), 16'($urandom_range(0, span)),
             16'($urandom_range(0, span)), 16'($urandom_range(0, span)),
             16'($urandom_range(0, span)), 16'($urandom_range(0, span))};
      end
    endcase
    return t;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic write_register(logic [2:0] addr, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_GRID_LAST) grid_model = value[GRID_W-1:0];
  endtask

  task automatic send_triangle(triangle_t t, tally_t want);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    shape_in <= t;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    expected_tallies.push_back(want);
  endtask

  task automatic send_random(int n);
    triangle_t t;
    repeat (n) begin
      t = random_triangle(grid_model);
      send_triangle(t, count_lattice_points(t, grid_model));
    end
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (expected_tallies.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    tally_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_tallies.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction count=%0d degenerate=%0d",
                                  point_count, degenerate));
      end else begin
        want = expected_tallies.pop_front();
        if (point_count !== want.count)
          report_mismatch($sformatf("point_count %0d, expected %0d", point_count, want.count));
        if (degenerate !== want.degen)
          report_mismatch($sformatf("degenerate %0b, expected %0b", degenerate, want.degen));
      end
    end
    result_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst || psel || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("triangle_lattice_point_count_tb: FAIL");
    $finish;
  end

  initial begin
    int sent;
    int n;
    int phase;
    logic [GRID_W-1:0] g;
    sent = 0;
    phase = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      send_triangle(directed_rows[k].shape, directed_rows[k].typed ? directed_rows[k].want :
                    count_lattice_points(directed_rows[k].shape, grid_model));
    end

    // A write outside the register map must leave the grid limit alone.
    drain_results();
    write_register(ADDR_UNUSED, $urandom());
    send_random(2);

    drain_results();
    write_register(ADDR_GRID_LAST, ($urandom() & 32'hFFFF_FF00) | 32'd255);
    send_triangle('{16'd0, 16'd0, 16'd65535, 16'd0, 16'd0, 16'd65535},
                  count_lattice_points('{16'd0, 16'd0, 16'd65535, 16'd0, 16'd0, 16'd65535},
                                       grid_model));
    send_random(2);

    drain_results();
    write_register(ADDR_GRID_LAST, $urandom() & 32'hFFFF_FF00);
    send_random(4);

    drain_results();
    write_register(ADDR_GRID_LAST, 32'd1);
    send_random(6);

    while (sent < RANDOM_ITEMS) begin
      drain_results();
      g = GRID_W'($urandom_range(2, 24));
      write_register(ADDR_GRID_LAST, {16'($urandom_range(0, 16'hFFFF)), 8'h00, g});
      calm <= (phase == 2);
      n = $urandom_range(8, 16);
      send_random(n);
      sent += n;
      phase++;
    end

    calm <= 1'b0;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("triangle_lattice_point_count_tb: PASS");
    end else begin
      $display("triangle_lattice_point_count_tb: FAIL");
    end
    $finish;
  end

endmodule
